[rtl/sliding_window_maximum_unit_defines.svh]
// Assertion helpers used by the checker file of this block.
`ifndef SLIDING_WINDOW_MAXIMUM_UNIT_DEFINES_SVH
`define SLIDING_WINDOW_MAXIMUM_UNIT_DEFINES_SVH

// Overlapping implication, disabled during reset.
`define SWM_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sliding window maximum: property violated");

// Next-cycle implication, disabled during reset.
`define SWM_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sliding window maximum: property violated");

// Next-cycle implication that also holds across reset.
`define SWM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sliding window maximum: reset property violated");

`endif

[rtl/swm_pkg.sv]
package swm_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CSR_W    = 7;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_RET   = 5'b00010,
      S_DROP  = 5'b00100,
      S_WRITE = 5'b01000,
      S_EMIT  = 5'b10000
   } state_type;

endpackage

[rtl/swm_cand_ram.sv]
module swm_cand_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int DW    = 39
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/sliding_window_maximum_unit.sv]
// Sliding-window maximum over a stream of signed 32-bit samples. The block keeps a
// monotonic list of candidate values and positions in a single-port-read ring memory
// and works on one sample at a time: after accepting an item it retires the candidates
// that fall out of the window from the head, then drops the smaller candidates from
// the tail, each such candidate costing one memory read, then writes the new item and
// moves to its emit step. A result waits in an output register, so the next item is
// taken while it is still stalled; if that next item yields a result, it then waits in
// its emit step for as long as the earlier result stays stalled. Once csr_window_size
// samples of the current array have arrived, each sample yields the window maximum; the
// sample marked last flags its result final, and if the array was shorter than the window
// it reports the maximum of the whole array with rsp_short_array set. The window size
// must be written only while the block is idle; the block does not enforce this. Zero
// acts as one, values above WINDOW_MAX as WINDOW_MAX.
module sliding_window_maximum_unit #(
   parameter int WINDOW_MAX = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [swm_pkg::SAMPLE_W-1:0]  req_sample,
   input  logic                                 req_last_sample,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [swm_pkg::SAMPLE_W-1:0]  rsp_window_max,
   output logic                                 rsp_is_final,
   output logic                                 rsp_short_array,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [swm_pkg::CSR_W-1:0]            csr_window_size
);
   import swm_pkg::*;

   localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int PW = $clog2(2 * WINDOW_MAX);
   localparam int CW = $clog2(WINDOW_MAX + 1);
   localparam int DW = SAMPLE_W + PW;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      if (p == AW'(WINDOW_MAX - 1)) begin
         return '0;
      end
      return p + AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
      if (p == '0) begin
         return AW'(WINDOW_MAX - 1);
      end
      return p - AW'(1);
   endfunction

   state_type            state_ff, state_in;
   logic [AW-1:0]        head_ff, head_in;
   logic [AW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [PW-1:0]        pos_ff, pos_in;
   logic [CW-1:0]        seen_ff, seen_in;
   logic [CW-1:0]        k_ff, k_in;
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic                 last_ff, last_in;
   logic                 fwd_ff, fwd_in;
   logic [CSR_W-1:0]     csr_window_size_ff, csr_window_size_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]  rsp_window_max_ff, rsp_window_max_in;
   logic                 rsp_is_final_ff, rsp_is_final_in;
   logic                 rsp_short_array_ff, rsp_short_array_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [DW-1:0]        wr_data;
   logic [AW-1:0]        rd_addr;
   logic [DW-1:0]        rd_data;

   logic [SAMPLE_W-1:0]  ent_value;
   logic [PW-1:0]        ent_pos;
   logic [PW:0]          age;
   logic                 retire;
   logic                 drop;
   logic                 ring_full;
   logic [AW-1:0]        head_w;
   logic [CW-1:0]        cnt_w;
   logic [31:0]          ws_ext;
   logic [CW-1:0]        k_eff;
   logic                 win_full;
   logic                 need_out;

   swm_cand_ram #(
      .DEPTH (WINDOW_MAX),
      .AW    (AW),
      .DW    (DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign ent_value = rd_data[DW-1:PW];
   assign ent_pos   = rd_data[PW-1:0];

   // Distance of the candidate behind the current position, modulo twice the window.
   assign age = {1'b0, pos_ff}
              + ((pos_ff >= ent_pos) ? (PW+1)'(0) : (PW+1)'(2 * WINDOW_MAX))
              - {1'b0, ent_pos};
   assign retire = (cnt_ff != '0) && (age >= (PW+1)'(k_ff));
   assign drop   = (cnt_ff != '0) && ($signed(ent_value) < $signed(sample_ff));

   assign ring_full = (cnt_ff == CW'(WINDOW_MAX));
   assign head_w    = ring_full ? ring_next(head_ff) : head_ff;
   assign cnt_w     = ring_full ? cnt_ff - CW'(1) : cnt_ff;

   assign ws_ext = 32'(csr_window_size_ff);
   assign k_eff  = (ws_ext == 32'd0) ? CW'(1) :
                   (ws_ext > 32'(WINDOW_MAX)) ? CW'(WINDOW_MAX) : CW'(ws_ext);

   assign win_full = (seen_ff >= k_ff);
   assign need_out = win_full || last_ff;

   assign wr_addr = tail_ff;
   assign wr_data = {sample_ff, pos_ff};

   always_comb begin
      state_in           = state_ff;
      head_in            = head_ff;
      tail_in            = tail_ff;
      cnt_in             = cnt_ff;
      pos_in             = pos_ff;
      seen_in            = seen_ff;
      k_in               = k_ff;
      sample_in          = sample_ff;
      last_in            = last_ff;
      fwd_in             = fwd_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_window_max_in  = rsp_window_max_ff;
      rsp_is_final_in    = rsp_is_final_ff;
      rsp_short_array_in = rsp_short_array_ff;
      rd_addr            = head_ff;
      wr_en              = 1'b0;

      csr_window_size_in = csr_window_size_ff;
      if (csr_valid) begin
         csr_window_size_in = csr_window_size;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               sample_in = req_sample;
               last_in   = req_last_sample;
               k_in      = k_eff;
               state_in  = S_RET;
            end
         end
         S_RET: begin
            if (retire) begin
               head_in = ring_next(head_ff);
               cnt_in  = cnt_ff - CW'(1);
               rd_addr = ring_next(head_ff);
            end else begin
               rd_addr  = ring_prev(tail_ff);
               state_in = S_DROP;
            end
         end
         S_DROP: begin
            if (drop) begin
               tail_in = ring_prev(tail_ff);
               cnt_in  = cnt_ff - CW'(1);
               rd_addr = ring_prev(ring_prev(tail_ff));
            end else begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            wr_en   = 1'b1;
            head_in = head_w;
            tail_in = ring_next(tail_ff);
            cnt_in  = cnt_w + CW'(1);
            pos_in  = (pos_ff == PW'(2 * WINDOW_MAX - 1)) ? '0 : pos_ff + PW'(1);
            if (seen_ff < CW'(WINDOW_MAX)) begin
               seen_in = seen_ff + CW'(1);
            end
            // The head read lands in the same cycle as the write; when the new
            // item is the head, the memory still returns the old contents.
            rd_addr  = head_w;
            fwd_in   = (head_w == tail_ff);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!need_out || !rsp_valid_ff || !rsp_stall) begin
               if (need_out) begin
                  rsp_valid_in       = 1'b1;
                  rsp_window_max_in  = fwd_ff ? sample_ff : ent_value;
                  rsp_is_final_in    = last_ff;
                  rsp_short_array_in = !win_full;
               end
               if (last_ff) begin
                  head_in = '0;
                  tail_in = '0;
                  cnt_in  = '0;
                  pos_in  = '0;
                  seen_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         head_ff            <= '0;
         tail_ff            <= '0;
         cnt_ff             <= '0;
         pos_ff             <= '0;
         seen_ff            <= '0;
         k_ff               <= CW'(1);
         fwd_ff             <= 1'b0;
         csr_window_size_ff <= CSR_W'(1);
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff           <= state_in;
         head_ff            <= head_in;
         tail_ff            <= tail_in;
         cnt_ff             <= cnt_in;
         pos_ff             <= pos_in;
         seen_ff            <= seen_in;
         k_ff               <= k_in;
         fwd_ff             <= fwd_in;
         csr_window_size_ff <= csr_window_size_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff          <= sample_in;
      last_ff            <= last_in;
      rsp_window_max_ff  <= rsp_window_max_in;
      rsp_is_final_ff    <= rsp_is_final_in;
      rsp_short_array_ff <= rsp_short_array_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_window_max  = rsp_window_max_ff;
   assign rsp_is_final    = rsp_is_final_ff;
   assign rsp_short_array = rsp_short_array_ff;

endmodule

[rtl/swm_checker.sv]
`include "sliding_window_maximum_unit_defines.svh"

module swm_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [swm_pkg::SAMPLE_W-1:0]  rsp_window_max,
   input logic                                 rsp_is_final,
   input logic                                 rsp_short_array
);

   logic req_take;
   logic rsp_hold;

   assign req_take = req_valid && !req_stall;
   assign rsp_hold = rsp_valid && rsp_stall;

   // A short array can only be reported on the closing item.
   `SWM_ASSERT_IMP(a_short_is_final, clock, reset, rsp_valid && rsp_short_array, rsp_is_final)

   // The block works on one item at a time, so it is busy right after taking one.
   `SWM_ASSERT_NXT(a_busy_after_take, clock, reset, req_take, req_stall)

   `SWM_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_hold,
                   rsp_valid && $stable(rsp_window_max) && $stable(rsp_is_final)
                   && $stable(rsp_short_array))

   `SWM_ASSERT_NXT_ALWAYS(a_reset_idle, clock, reset, !rsp_valid && !req_stall)

endmodule

bind sliding_window_maximum_unit swm_checker u_swm_checker (.*);
